[hdl/sps_pkg.sv]
// Shared types, timing constants and helper functions for the strobe pulse and
// set point sequencer. No dependencies; imported by sps_step and the top level.
package sps_pkg;

    // Timing constants, all in microseconds.
    localparam int REARM_US       = 32258;   // 1e6 / 31
    localparam int PULSE_CAP_US   = 20000;
    localparam int SEND_DELAY_US  = 1000;
    localparam int SEND_TIME_US   = 2500;
    localparam int SYNC_US        = 1000;
    localparam int RESEND_US      = 200000;
    localparam int PERIOD_UNIT_US = 100;

    localparam int UPDATE_BITS = 18;
    localparam int PERIOD_US_BITS = 23;
    localparam int CFG_IDX_BITS = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_PERIOD = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_LENGTH = CFG_IDX_BITS'(1);

    typedef enum logic [1:0] {
        MS_IDLE   = 2'd0,
        MS_PULSE  = 2'd1,
        MS_BREAK  = 2'd2,
        MS_SERIAL = 2'd3
    } t_mstate;

    // Sequencer state apart from the wide timers.
    typedef struct packed {
        t_mstate                mstate;
        logic                   pending_valid;
        logic                   gen_pulse_on;
        logic                   gen_sync_on;
        logic                   serial_line;
        logic [7:0]             pending_visible;
        logic [7:0]             pending_uv;
        logic [7:0]             stored_visible;
        logic [7:0]             stored_uv;
        logic [UPDATE_BITS-1:0] since_update;
    } t_ctrl;

    // One result word.
    typedef struct packed {
        logic       strobe_level;
        logic       sync_level;
        logic       line_is_serial;
        logic       send_frame;
        logic [7:0] frame_visible;
        logic [7:0] frame_uv;
        logic       pulse_skipped;
        logic       pulse_overlong;
    } t_result;

    function automatic logic [PERIOD_US_BITS-1:0] period_to_us(input logic [15:0] p);
        return PERIOD_US_BITS'(p) * PERIOD_US_BITS'(PERIOD_UNIT_US);
    endfunction

endpackage

[hdl/sps_step.sv]
// Combinational next-state and result logic for one input word of the sequencer.
// Depends on sps_pkg for the state and result structs and the timing constants.
module sps_step
    import sps_pkg::*;
#(
    parameter int TIMER_BITS = 24
) (
    input  logic [15:0]           i_period,
    input  logic [15:0]           i_length,
    input  t_ctrl                 i_ctrl,
    input  logic [TIMER_BITS-1:0] i_since_pulse,
    input  logic [TIMER_BITS-1:0] i_since_serial,
    input  logic [TIMER_BITS-1:0] i_since_nominal,
    input  logic [9:0]            i_advance_us,
    input  logic                  i_trigger_level,
    input  logic                  i_setpoint_write,
    input  logic [7:0]            i_visible_value,
    input  logic [7:0]            i_uv_value,
    output t_ctrl                 o_ctrl,
    output logic [TIMER_BITS-1:0] o_since_pulse,
    output logic [TIMER_BITS-1:0] o_since_serial,
    output logic [TIMER_BITS-1:0] o_since_nominal,
    output t_result               o_result
);

    localparam int CW = (TIMER_BITS > PERIOD_US_BITS) ? TIMER_BITS : PERIOD_US_BITS;

    function automatic logic [TIMER_BITS-1:0] sat_add(input logic [TIMER_BITS-1:0] t,
                                                      input logic [9:0] a);
        logic [TIMER_BITS:0] s;
        s = {1'b0, t} + (TIMER_BITS+1)'(a);
        return s[TIMER_BITS] ? {TIMER_BITS{1'b1}} : s[TIMER_BITS-1:0];
    endfunction

    logic [PERIOD_US_BITS-1:0] w_period_us;
    assign w_period_us = period_to_us(i_period);

    always_comb begin
        t_ctrl                   c;
        t_result                 r;
        logic [TIMER_BITS-1:0]   ps;
        logic [TIMER_BITS-1:0]   ss;
        logic [TIMER_BITS-1:0]   np;
        logic [UPDATE_BITS:0]    us;
        logic [CW-1:0]           el_w;
        logic [CW-1:0]           per_w;

        c = i_ctrl;
        r = '0;

        // All timers advance first, each saturating.
        ps = sat_add(i_since_pulse, i_advance_us);
        ss = sat_add(i_since_serial, i_advance_us);
        np = sat_add(i_since_nominal, i_advance_us);
        us = {1'b0, i_ctrl.since_update} + (UPDATE_BITS+1)'(i_advance_us);
        c.since_update = us[UPDATE_BITS] ? {UPDATE_BITS{1'b1}} : us[UPDATE_BITS-1:0];

        // A new set point is sent at once when the machine is idle.
        if (i_setpoint_write) begin
            c.pending_valid   = 1'b1;
            c.pending_visible = i_visible_value;
            c.pending_uv      = i_uv_value;
            if (c.mstate == MS_IDLE) begin
                ss              = '0;
                c.mstate        = MS_SERIAL;
                c.serial_line   = 1'b1;
                r.send_frame    = 1'b1;
                r.frame_visible = c.pending_visible;
                r.frame_uv      = c.pending_uv;
                c.pending_valid = 1'b0;
            end
            c.stored_visible = i_visible_value;
            c.stored_uv      = i_uv_value;
            c.since_update   = '0;
        end

        case (c.mstate)
            MS_PULSE: begin
                if (ps >= TIMER_BITS'(PULSE_CAP_US)) begin
                    r.pulse_overlong = 1'b1;
                    c.mstate         = MS_BREAK;
                end
            end
            MS_BREAK: begin
                if (c.pending_valid && ps >= TIMER_BITS'(PULSE_CAP_US + SEND_DELAY_US)) begin
                    ss              = '0;
                    c.mstate        = MS_SERIAL;
                    c.serial_line   = 1'b1;
                    r.send_frame    = 1'b1;
                    r.frame_visible = c.pending_visible;
                    r.frame_uv      = c.pending_uv;
                    c.pending_valid = 1'b0;
                end
                if (ps >= TIMER_BITS'(REARM_US)) begin
                    c.serial_line = 1'b0;
                    c.mstate      = MS_IDLE;
                end
            end
            MS_SERIAL: begin
                if (ss >= TIMER_BITS'(SEND_TIME_US)) begin
                    if (ps >= TIMER_BITS'(REARM_US)) begin
                        c.serial_line = 1'b0;
                        c.mstate      = MS_IDLE;
                    end else begin
                        c.mstate = MS_BREAK;
                    end
                end
            end
            default: begin
            end
        endcase

        el_w  = CW'(np);
        per_w = CW'(w_period_us);
        if (i_period != 16'd0) begin
            // Internal generator.
            if (c.gen_pulse_on && np > TIMER_BITS'(i_length)) begin
                if (c.mstate == MS_PULSE) begin
                    c.mstate = MS_BREAK;
                end
                c.gen_pulse_on = 1'b0;
            end
            if (c.gen_sync_on && np > TIMER_BITS'(SYNC_US)) begin
                c.gen_sync_on = 1'b0;
            end
            if (!c.gen_pulse_on && !c.gen_sync_on && el_w > per_w) begin
                if (c.mstate != MS_IDLE) begin
                    r.pulse_skipped = 1'b1;
                end else begin
                    c.mstate = MS_PULSE;
                    ps       = '0;
                end
                c.gen_pulse_on = 1'b1;
                c.gen_sync_on  = 1'b1;
                np             = TIMER_BITS'(el_w - per_w);
            end
        end else begin
            // External trigger: rising level starts, falling level ends.
            if (!c.gen_pulse_on && i_trigger_level) begin
                c.gen_pulse_on = 1'b1;
                if (c.mstate != MS_IDLE) begin
                    r.pulse_skipped = 1'b1;
                end else begin
                    c.mstate = MS_PULSE;
                    ps       = '0;
                end
            end
            if (c.gen_pulse_on && !i_trigger_level) begin
                c.gen_pulse_on = 1'b0;
                if (c.mstate == MS_PULSE) begin
                    c.mstate = MS_BREAK;
                end
            end
        end

        // Periodic resend of the stored set point.
        if (c.since_update > UPDATE_BITS'(RESEND_US)) begin
            c.pending_valid   = 1'b1;
            c.pending_visible = c.stored_visible;
            c.pending_uv      = c.stored_uv;
            if (c.mstate == MS_IDLE) begin
                ss              = '0;
                c.mstate        = MS_SERIAL;
                c.serial_line   = 1'b1;
                r.send_frame    = 1'b1;
                r.frame_visible = c.pending_visible;
                r.frame_uv      = c.pending_uv;
                c.pending_valid = 1'b0;
            end
            c.since_update = '0;
        end

        r.strobe_level   = (c.mstate == MS_PULSE);
        r.sync_level     = c.gen_sync_on;
        r.line_is_serial = c.serial_line;

        o_ctrl          = c;
        o_since_pulse   = ps;
        o_since_serial  = ss;
        o_since_nominal = np;
        o_result        = r;
    end

endmodule

[hdl/strobe_pulse_and_setpoint_sequencer_unit.sv]
// Top level of the strobe pulse and set point sequencer: handshakes, registers
// and configuration. Depends on sps_pkg and sps_step.
//
//  Channel   Direction  Handshake                  Word carried
//  -------   ---------  -------------------------  ----------------------------------
//  in        to block   i_in_valid / o_in_ready    advance, trigger, set point
//  out       from block o_out_valid / i_out_ready  strobe, sync, serial, frame, flags
//  cfg       to block   i_cfg_valid / o_cfg_ready  register index and write data
//
// One word is accepted in every cycle unless the output stalls. A word taken
// at a clock edge sits in the input register, passes through the single-pass step
// logic and lands in the result register, where it raises o_out_valid; a stalled
// output keeps it waiting first. The rate is set by that one step stage.
// Reset is synchronous and active low; it restores every timer, flag and control
// register at once (payload registers are not reset), so no clearing pass is needed.
// When the output is stalled the result register holds, one further word waits
// in the input register, and only then does o_in_ready drop.
module strobe_pulse_and_setpoint_sequencer_unit
    import sps_pkg::*;
#(
    parameter int TIMER_BITS = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [9:0]              i_advance_us,
    input  logic                    i_trigger_level,
    input  logic                    i_setpoint_write,
    input  logic [7:0]              i_visible_value,
    input  logic [7:0]              i_uv_value,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_strobe_level,
    output logic                    o_sync_level,
    output logic                    o_line_is_serial,
    output logic                    o_send_frame,
    output logic [7:0]              o_frame_visible,
    output logic [7:0]              o_frame_uv,
    output logic                    o_pulse_skipped,
    output logic                    o_pulse_overlong,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [15:0]             i_cfg_data
);

    localparam int CW = (TIMER_BITS > PERIOD_US_BITS) ? TIMER_BITS : PERIOD_US_BITS;

    // Input register.
    logic        r_in_valid;
    logic [9:0]  r_in_advance;
    logic        r_in_trigger;
    logic        r_in_write;
    logic [7:0]  r_in_visible;
    logic [7:0]  r_in_uv;

    // Sequencer state and configuration.
    t_ctrl                 r_ctrl, n_ctrl;
    logic [TIMER_BITS-1:0] r_since_pulse, n_since_pulse;
    logic [TIMER_BITS-1:0] r_since_serial, n_since_serial;
    logic [TIMER_BITS-1:0] r_since_nominal, n_since_nominal;
    logic [15:0]           r_period;
    logic [15:0]           r_length;

    // Result register.
    logic    r_out_valid;
    t_result r_out, n_out;

    logic w_advance;
    logic w_in_accept;
    logic w_cfg_write;
    logic [CW-1:0] w_new_period_us;
    logic [TIMER_BITS-1:0] w_nominal_init;

    // The stored word moves on whenever the result register is free or emptying.
    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign w_in_accept = i_in_valid && o_in_ready;
    // A register write is taken only while no word waits to be processed, so it
    // never lands in the same cycle as a state update.
    assign o_cfg_ready = !r_in_valid;
    assign w_cfg_write = i_cfg_valid && o_cfg_ready;

    // Enabling the generator loads the nominal timer with the period, held to
    // the timer's range; the first advance would saturate it there anyway.
    assign w_new_period_us = CW'(period_to_us(i_cfg_data));
    assign w_nominal_init  = (w_new_period_us > CW'({TIMER_BITS{1'b1}})) ?
                             {TIMER_BITS{1'b1}} : TIMER_BITS'(w_new_period_us);

    sps_step #(
        .TIMER_BITS(TIMER_BITS)
    ) u_step (
        .i_period        (r_period),
        .i_length        (r_length),
        .i_ctrl          (r_ctrl),
        .i_since_pulse   (r_since_pulse),
        .i_since_serial  (r_since_serial),
        .i_since_nominal (r_since_nominal),
        .i_advance_us    (r_in_advance),
        .i_trigger_level (r_in_trigger),
        .i_setpoint_write(r_in_write),
        .i_visible_value (r_in_visible),
        .i_uv_value      (r_in_uv),
        .o_ctrl          (n_ctrl),
        .o_since_pulse   (n_since_pulse),
        .o_since_serial  (n_since_serial),
        .o_since_nominal (n_since_nominal),
        .o_result        (n_out)
    );

    // Control state, timers and configuration, all set to their start values by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid             <= 1'b0;
            r_out_valid            <= 1'b0;
            r_ctrl.mstate          <= MS_IDLE;
            r_ctrl.pending_valid   <= 1'b0;
            r_ctrl.gen_pulse_on    <= 1'b0;
            r_ctrl.gen_sync_on     <= 1'b0;
            r_ctrl.serial_line     <= 1'b0;
            r_ctrl.pending_visible <= 8'd0;
            r_ctrl.pending_uv      <= 8'd0;
            r_ctrl.stored_visible  <= 8'd0;
            r_ctrl.stored_uv       <= 8'd0;
            r_ctrl.since_update    <= UPDATE_BITS'(RESEND_US);
            r_since_pulse          <= TIMER_BITS'(REARM_US);
            r_since_serial         <= TIMER_BITS'(REARM_US);
            r_since_nominal        <= '0;
            r_period               <= 16'd0;
            r_length               <= 16'd0;
        end else begin
            if (w_in_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end

            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (w_advance) begin
                r_ctrl          <= n_ctrl;
                r_since_pulse   <= n_since_pulse;
                r_since_serial  <= n_since_serial;
                r_since_nominal <= n_since_nominal;
            end

            // Register writes come only while no word waits in the input register.
            if (w_cfg_write) begin
                case (i_cfg_index)
                    CFG_PERIOD: begin
                        r_period <= i_cfg_data;
                        if (r_period == 16'd0) begin
                            r_since_nominal <= w_nominal_init;
                        end
                    end
                    CFG_LENGTH: begin
                        r_length <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_advance <= i_advance_us;
            r_in_trigger <= i_trigger_level;
            r_in_write   <= i_setpoint_write;
            r_in_visible <= i_visible_value;
            r_in_uv      <= i_uv_value;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_strobe_level   = r_out.strobe_level;
    assign o_sync_level     = r_out.sync_level;
    assign o_line_is_serial = r_out.line_is_serial;
    assign o_send_frame     = r_out.send_frame;
    assign o_frame_visible  = r_out.frame_visible;
    assign o_frame_uv       = r_out.frame_uv;
    assign o_pulse_skipped  = r_out.pulse_skipped;
    assign o_pulse_overlong = r_out.pulse_overlong;

    // A pulse cut short by the pulse cap leaves the machine out of the pulse.
    a_overlong_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.pulse_overlong |-> !r_out.strobe_level)
        else $error("overlong pulse reported while strobe still high");

    // The strobe and the serial hand-over never share the first pin.
    a_pin_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.strobe_level |-> !r_out.line_is_serial)
        else $error("strobe high while line handed to serial");

    // A word held back by a stalled output stays in the input register.
    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_in_advance)
                                     && $stable(r_in_write))
        else $error("held input word lost or changed");

    // The machine only moves when a word is processed.
    a_state_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> $stable(r_ctrl.mstate) && $stable(r_since_pulse))
        else $error("sequencer state changed without an input word");

endmodule

[tb/strobe_pulse_and_setpoint_sequencer_unit_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for strobe_pulse_and_setpoint_sequencer_unit.
// Depends on sps_pkg and the unit itself; an in-bench predictor of the strobe
// machine produces the expected result word for every accepted input word.
module strobe_pulse_and_setpoint_sequencer_unit_test;
    import sps_pkg::*;

    localparam int TIMER_BITS = 24;
    localparam longint TIMER_MAX = (longint'(1) << TIMER_BITS) - 1;
    localparam longint UPDATE_MAX = (longint'(1) << UPDATE_BITS) - 1;

    // An index that names no register; a write to it must change nothing.
    localparam logic [CFG_IDX_BITS-1:0] CFG_NONE = '1;

    localparam int NUM_PHASES = 11;
    localparam int PHASE_WORDS = 100;
    localparam int PICK_RANDOM = -1;
    localparam int PRESSURE_PHASE = 1;
    localparam int SPARE_PHASE = 5;
    localparam int LONG_HOLD = 80;
    // Enough words at the largest advance to carry the pulse and serial timers past their thresholds.
    localparam int SOAK_WORDS = 180;
    localparam int DIRECTED_ROWS = 23;
    localparam int PRINT_LIMIT = 50;

    // Result words that can be read straight off the behaviour.
    localparam t_result QUIET_WORD = '0;
    localparam t_result RESEND_WORD = '{strobe_level: 1'b0, sync_level: 1'b0,
        line_is_serial: 1'b1, send_frame: 1'b1, frame_visible: 8'd0, frame_uv: 8'd0,
        pulse_skipped: 1'b0, pulse_overlong: 1'b0};
    localparam t_result SKIP_WORD = '{strobe_level: 1'b0, sync_level: 1'b0,
        line_is_serial: 1'b1, send_frame: 1'b0, frame_visible: 8'd0, frame_uv: 8'd0,
        pulse_skipped: 1'b1, pulse_overlong: 1'b0};

    typedef struct packed {
        logic [9:0] adv;
        logic       trig;
        logic       wr;
        logic [7:0] vis;
        logic [7:0] uv;
        logic       typed;
        t_result    want;
    } t_directed_row;

    logic clk;
    logic rst_n = 1'b0;

    logic                    in_valid = 1'b0;
    logic [9:0]              advance_us = '0;
    logic                    trigger_level = 1'b0;
    logic                    setpoint_write = 1'b0;
    logic [7:0]              visible_value = '0;
    logic [7:0]              uv_value = '0;
    logic                    out_ready = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [15:0]             cfg_data = '0;

    logic       in_ready, out_valid, cfg_ready;
    logic       strobe_level, sync_level, line_is_serial, send_frame;
    logic [7:0] frame_visible, frame_uv;
    logic       pulse_skipped, pulse_overlong;

    strobe_pulse_and_setpoint_sequencer_unit #(
        .TIMER_BITS(TIMER_BITS)
    ) uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_advance_us    (advance_us),
        .i_trigger_level (trigger_level),
        .i_setpoint_write(setpoint_write),
        .i_visible_value (visible_value),
        .i_uv_value      (uv_value),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_strobe_level  (strobe_level),
        .o_sync_level    (sync_level),
        .o_line_is_serial(line_is_serial),
        .o_send_frame    (send_frame),
        .o_frame_visible (frame_visible),
        .o_frame_uv      (frame_uv),
        .o_pulse_skipped (pulse_skipped),
        .o_pulse_overlong(pulse_overlong),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // A generous fixed limit; a correct run finishes in a small fraction of it.
    initial begin
        #40_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor state: the strobe machine, its timers and its registers.
    // Timers are held wide and clamped by hand to the block's widths.
    // ------------------------------------------------------------------
    t_mstate    seq_state;
    longint     pulse_age, serial_age, nominal_age, setpoint_age;
    logic       held_valid, gen_pulse, gen_sync, line_serial;
    logic [7:0] held_visible, held_uv, stored_visible, stored_uv;
    logic [15:0] period_reg, length_reg;
    t_result    step_word;

    // Result words still owed by the block, oldest first.
    t_result strobe_words_due[$];

    int  mismatch_count = 0;
    int  words_seen = 0;
    logic calm = 1'b0;
    int  holds_asked = 0;
    int  holds_served = 0;
    logic trig_level_now = 1'b0;
    int  trig_run_left = 0;

    int phase_period [NUM_PHASES] = '{0, 250, 400, 1, 0, 65535, 320,
                                      PICK_RANDOM, PICK_RANDOM, PICK_RANDOM, 0};
    int phase_length [NUM_PHASES] = '{0, 5000, 25000, 0, 0, 65535, 1000,
                                      PICK_RANDOM, PICK_RANDOM, PICK_RANDOM, 65535};
    int phase_wr_pct [NUM_PHASES] = '{3, 2, 0, 5, 2, 3, 1, 4, 0, 2, 2};

    function automatic longint timer_add(input longint t, input longint a,
                                         input longint lim);
        return (t + a > lim) ? lim : t + a;
    endfunction

    // Hands the waiting set point to the serial transmitter, if there is one.
    function automatic void launch_frame();
        if (held_valid) begin
            serial_age = 0;
            seq_state = MS_SERIAL;
            line_serial = 1'b1;
            step_word.send_frame = 1'b1;
            step_word.frame_visible = held_visible;
            step_word.frame_uv = held_uv;
            held_valid = 1'b0;
        end
    endfunction

    function automatic void rearm_line();
        line_serial = 1'b0;
        seq_state = MS_IDLE;
    endfunction

    function automatic void try_start_pulse();
        if (seq_state != MS_IDLE) begin
            step_word.pulse_skipped = 1'b1;
        end else begin
            seq_state = MS_PULSE;
            pulse_age = 0;
        end
    endfunction

    // An end request outside a pulse is simply dropped.
    function automatic void finish_pulse();
        if (seq_state == MS_PULSE) seq_state = MS_BREAK;
    endfunction

    function automatic void accept_setpoint(input logic [7:0] vis, input logic [7:0] uv);
        held_valid = 1'b1;
        held_visible = vis;
        held_uv = uv;
        if (seq_state == MS_IDLE) begin
            seq_state = MS_BREAK;
            launch_frame();
        end
    endfunction

    // One input word's worth of work: timers, set point, machine, pulse source,
    // periodic resend, in that order.
    function automatic t_result advance_strobe_machine(input logic [9:0] adv,
            input logic trig, input logic wr, input logic [7:0] vis, input logic [7:0] uv);
        longint period_us, el;
        step_word = '0;
        pulse_age = timer_add(pulse_age, adv, TIMER_MAX);
        serial_age = timer_add(serial_age, adv, TIMER_MAX);
        nominal_age = timer_add(nominal_age, adv, TIMER_MAX);
        setpoint_age = timer_add(setpoint_age, adv, UPDATE_MAX);

        if (wr) begin
            accept_setpoint(vis, uv);
            stored_visible = vis;
            stored_uv = uv;
            setpoint_age = 0;
        end

        case (seq_state)
            MS_PULSE: begin
                if (pulse_age >= PULSE_CAP_US) begin
                    step_word.pulse_overlong = 1'b1;
                    finish_pulse();
                end
            end
            MS_BREAK: begin
                // Sending and rearming may both fall in the same word.
                if (held_valid && pulse_age >= PULSE_CAP_US + SEND_DELAY_US) launch_frame();
                if (pulse_age >= REARM_US) rearm_line();
            end
            MS_SERIAL: begin
                if (serial_age >= SEND_TIME_US) begin
                    if (pulse_age >= REARM_US) rearm_line();
                    else seq_state = MS_BREAK;
                end
            end
            default: ;
        endcase

        if (period_reg != 0) begin
            period_us = longint'(period_reg) * PERIOD_UNIT_US;
            el = nominal_age;
            if (gen_pulse && el > length_reg) begin
                finish_pulse();
                gen_pulse = 1'b0;
            end
            if (gen_sync && el > SYNC_US) gen_sync = 1'b0;
            if (!gen_pulse && !gen_sync && el > period_us) begin
                try_start_pulse();
                gen_pulse = 1'b1;
                gen_sync = 1'b1;
                nominal_age = el - period_us;
            end
        end else begin
            // External mode follows trigger edges; the sync level is left alone.
            if (!gen_pulse && trig) begin
                gen_pulse = 1'b1;
                try_start_pulse();
            end
            if (gen_pulse && !trig) begin
                gen_pulse = 1'b0;
                finish_pulse();
            end
        end

        if (setpoint_age > RESEND_US) begin
            accept_setpoint(stored_visible, stored_uv);
            setpoint_age = 0;
        end

        step_word.strobe_level = (seq_state == MS_PULSE);
        step_word.sync_level = gen_sync;
        step_word.line_is_serial = line_serial;
        return step_word;
    endfunction

    // Mostly back-to-back, sometimes a short pause, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("MISMATCH at result word %0d, %s: got %0d, expected %0d",
                     words_seen, what, got, want);
    endtask

    // Offers one input word and holds it until the block takes it. The expected
    // word is worked out at the edge of acceptance. Valid is only lowered when a
    // pause follows, so a following word never sees valid dropped and raised in
    // one step.
    task automatic offer_word(input logic [9:0] adv, input logic trig, input logic wr,
            input logic [7:0] vis, input logic [7:0] uv, input logic typed,
            input t_result want, input int gap);
        t_result predicted;
        in_valid <= 1'b1;
        advance_us <= adv;
        trigger_level <= trig;
        setpoint_write <= wr;
        visible_value <= vis;
        uv_value <= uv;
        do @(posedge clk); while (!in_ready);
        predicted = advance_strobe_machine(adv, trig, wr, vis, uv);
        strobe_words_due.push_back(typed ? want : predicted);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Register writes happen only with nothing in flight, so the predictor can
    // take the new value at the edge of acceptance.
    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_PERIOD) begin
            // Leaving external mode loads the nominal timer with the new period.
            if (period_reg == 0) nominal_age = longint'(data) * PERIOD_UNIT_US;
            period_reg = data;
        end else if (idx == CFG_LENGTH) begin
            length_reg = data;
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: checks each accepted word against the oldest expectation
    // and drives the ready line with random stalls. A long hold-off requested
    // by the stimulus is counted out here, cycle by cycle.
    // ------------------------------------------------------------------
    int ready_gap_left = 0;
    int hold_left = 0;

    always @(posedge clk) begin : result_checker
        t_result want;
        if (out_valid && out_ready) begin
            words_seen++;
            if (strobe_words_due.size() == 0) begin
                report_mismatch("word with nothing expected", 1, 0);
            end else begin
                want = strobe_words_due.pop_front();
                if (strobe_level !== want.strobe_level)
                    report_mismatch("strobe_level", strobe_level, want.strobe_level);
                if (sync_level !== want.sync_level)
                    report_mismatch("sync_level", sync_level, want.sync_level);
                if (line_is_serial !== want.line_is_serial)
                    report_mismatch("line_is_serial", line_is_serial, want.line_is_serial);
                if (send_frame !== want.send_frame)
                    report_mismatch("send_frame", send_frame, want.send_frame);
                if (frame_visible !== want.frame_visible)
                    report_mismatch("frame_visible", frame_visible, want.frame_visible);
                if (frame_uv !== want.frame_uv)
                    report_mismatch("frame_uv", frame_uv, want.frame_uv);
                if (pulse_skipped !== want.pulse_skipped)
                    report_mismatch("pulse_skipped", pulse_skipped, want.pulse_skipped);
                if (pulse_overlong !== want.pulse_overlong)
                    report_mismatch("pulse_overlong", pulse_overlong, want.pulse_overlong);
            end
        end

        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (holds_asked != holds_served) begin
            holds_served++;
            hold_left = LONG_HOLD;
            out_ready <= 1'b0;
        end else if (ready_gap_left > 0) begin
            ready_gap_left--;
            out_ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 99) < 25) ready_gap_left = pick_gap();
            out_ready <= (ready_gap_left == 0);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: a directed table, a soak that carries the pulse and serial timers
    // far past their thresholds, and then random phases, each under its own
    // register setting.
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_directed_row directed_rows [DIRECTED_ROWS];
        t_directed_row row;
        int gap, burst_left, period_val, length_val, r;
        logic [9:0] adv_v;
        logic trig_v, wr_v;
        logic [7:0] vis_v, uv_v;

        // External mode throughout. The first rows run from reset: a quiet word,
        // then the first periodic resend of the zero set point, a new set point
        // arriving while the frame is still on the line, a trigger refused
        // during serial, an end request outside a pulse, and so on into a pulse
        // and its break.
        directed_rows = '{
            '{10'd0,    1'b0, 1'b0, 8'd0,   8'd0,   1'b1, QUIET_WORD},
            '{10'd1023, 1'b0, 1'b0, 8'd0,   8'd0,   1'b1, RESEND_WORD},
            '{10'd0,    1'b0, 1'b1, 8'd255, 8'd255, 1'b0, QUIET_WORD},
            '{10'd1023, 1'b1, 1'b0, 8'd0,   8'd0,   1'b1, SKIP_WORD},
            '{10'd1023, 1'b0, 1'b0, 8'd0,   8'd0,   1'b0, QUIET_WORD},
            '{10'd1023, 1'b0, 1'b0, 8'd0,   8'd0,   1'b0, QUIET_WORD},
            '{10'd1,    1'b1, 1'b0, 8'd170, 8'd85,  1'b0, QUIET_WORD},
            '{10'd1023, 1'b1, 1'b0, 8'd0,   8'd0,   1'b0, QUIET_WORD},
            '{10'd1023, 1'b1, 1'b1, 8'd0,   8'd0,   1'b0, QUIET_WORD},
            '{10'd1023, 1'b0, 1'b0, 8'd0,   8'd0,   1'b0, QUIET_WORD},
            '{10'h2AA,  1'b0, 1'b1, 8'hAA,  8'h55,  1'b0, QUIET_WORD},
            '{10'h155,  1'b0, 1'b1, 8'h55,  8'hAA,  1'b0, QUIET_WORD},
            '{10'd1023, 1'b1, 1'b0, 8'd0,   8'd0,   1'b0, QUIET_WORD},
            '{10'd1023, 1'b0, 1'b0, 8'd0,   8'd0,   1'b0, QUIET_WORD},
            '{10'd0,    1'b1, 1'b0, 8'd0,   8'd0,   1'b0, QUIET_WORD},
            '{10'd0,    1'b0, 1'b0, 8'd0,   8'd0,   1'b0, QUIET_WORD},
            '{10'd1023, 1'b0, 1'b1, 8'd255, 8'd0,   1'b0, QUIET_WORD},
            '{10'd1023, 1'b1, 1'b0, 8'd0,   8'd0,   1'b0, QUIET_WORD},
            '{10'd1023, 1'b1, 1'b0, 8'd0,   8'd0,   1'b0, QUIET_WORD},
            '{10'd1023, 1'b0, 1'b1, 8'd0,   8'd255, 1'b0, QUIET_WORD},
            '{10'd512,  1'b0, 1'b0, 8'd0,   8'd0,   1'b0, QUIET_WORD},
            '{10'd1023, 1'b1, 1'b0, 8'd0,   8'd0,   1'b0, QUIET_WORD},
            '{10'd1023, 1'b0, 1'b0, 8'd0,   8'd0,   1'b0, QUIET_WORD}
        };

        seq_state = MS_IDLE;
        pulse_age = REARM_US;
        serial_age = REARM_US;
        nominal_age = 0;
        setpoint_age = RESEND_US;
        held_valid = 1'b0;
        held_visible = '0;
        held_uv = '0;
        stored_visible = '0;
        stored_uv = '0;
        gen_pulse = 1'b0;
        gen_sync = 1'b0;
        line_serial = 1'b0;
        period_reg = '0;
        length_reg = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            offer_word(row.adv, row.trig, row.wr, row.vis, row.uv, row.typed, row.want,
                       pick_gap());
        end

        // Soak: no triggers and no writes, while the pulse and serial timers run far
        // past every one of their thresholds.
        repeat (SOAK_WORDS)
            offer_word(10'd1023, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0, QUIET_WORD, pick_gap());

        for (int p = 0; p < NUM_PHASES; p++) begin
            // Let every expected word come back before touching the registers.
            in_valid <= 1'b0;
            while (strobe_words_due.size() != 0) @(posedge clk);
            repeat (4) @(posedge clk);

            calm = (p == 3) || (p == 8);
            period_val = (phase_period[p] == PICK_RANDOM) ? $urandom_range(1, 700)
                                                          : phase_period[p];
            length_val = (phase_length[p] == PICK_RANDOM) ? $urandom_range(0, 40000)
                                                          : phase_length[p];
            write_register(CFG_PERIOD, period_val[15:0]);
            write_register(CFG_LENGTH, length_val[15:0]);
            if (p == SPARE_PHASE) write_register(CFG_NONE, 16'($urandom_range(0, 65535)));

            burst_left = 0;
            for (int k = 0; k < PHASE_WORDS; k++) begin
                // Midway through the pressure phase the result side holds off
                // for a long while and words keep coming back to back, so the
                // block fills and drops its input ready.
                if (p == PRESSURE_PHASE && k == PHASE_WORDS / 2) begin
                    holds_asked++;
                    burst_left = 30;
                end

                r = $urandom_range(0, 99);
                if (r < 8) adv_v = 10'd0;
                else if (r < 16) adv_v = 10'd1023;
                else if (r < 40) adv_v = 10'($urandom_range(1, 63));
                else adv_v = 10'($urandom_range(64, 1022));

                // The trigger is held in runs, long enough at times to reach
                // the pulse limit, with the odd single-word glitch.
                if (trig_run_left == 0) begin
                    trig_level_now = !trig_level_now;
                    trig_run_left = trig_level_now ? $urandom_range(1, 40)
                                                   : $urandom_range(1, 60);
                end
                trig_run_left--;
                trig_v = trig_level_now;
                if ($urandom_range(0, 99) < 4) trig_v = !trig_v;

                wr_v = ($urandom_range(0, 99) < phase_wr_pct[p]);
                vis_v = 8'($urandom_range(0, 255));
                uv_v = 8'($urandom_range(0, 255));

                if (burst_left > 0) begin
                    burst_left--;
                    gap = 0;
                end else begin
                    gap = pick_gap();
                end
                offer_word(adv_v, trig_v, wr_v, vis_v, uv_v, 1'b0, QUIET_WORD, gap);
            end
        end

        in_valid <= 1'b0;
        while (strobe_words_due.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
